/* rtl/lrutc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lrutc_pkg
// Shared types and codes for the LRU translation cache.
// ----------------------------------------------------------------------------
package lrutc_pkg;

    localparam int VA_W  = 32;
    localparam int PID_W = 22;
    localparam int MA_W  = 32;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    typedef struct packed {
        logic             op;
        logic [VA_W-1:0]  virt_addr;
        logic [PID_W-1:0] proc_id;
        logic [MA_W-1:0]  new_mach_addr;
    } lrutc_req_t;

    typedef struct packed {
        logic            hit;
        logic [MA_W-1:0] found_mach_addr;
    } lrutc_resp_t;

    // one stored translation
    typedef struct packed {
        logic [VA_W-1:0]  virt_addr;
        logic [PID_W-1:0] proc_id;
        logic [MA_W-1:0]  mach_addr;
    } lrutc_entry_t;

endpackage : lrutc_pkg
`default_nettype wire

/* rtl/lrutc_store.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lrutc_store
// Entry and rank memories: one registered read port, one write port each.
// ----------------------------------------------------------------------------
module lrutc_store
    import lrutc_pkg::*;
#(
    parameter int CACHE_ENTRIES = 32
) (
    input  wire logic                              aclk,
    input  wire logic [$clog2(CACHE_ENTRIES)-1:0]   rd_addr,
    output      lrutc_entry_t                      rd_entry,
    output      logic [2*$clog2(CACHE_ENTRIES)-1:0] rd_rank,
    input  wire logic                              entry_we,
    input  wire logic [$clog2(CACHE_ENTRIES)-1:0]   entry_waddr,
    input  wire lrutc_entry_t                      entry_wdata,
    input  wire logic                              rank_we,
    input  wire logic [$clog2(CACHE_ENTRIES)-1:0]   rank_waddr,
    input  wire logic [2*$clog2(CACHE_ENTRIES)-1:0] rank_wdata
);

    localparam int IDX_W = $clog2(CACHE_ENTRIES);

    lrutc_entry_t           entry_mem [CACHE_ENTRIES];
    logic [2*IDX_W-1:0]     rank_mem  [CACHE_ENTRIES];
    lrutc_entry_t           rd_entry_reg;
    logic [2*IDX_W-1:0]     rd_rank_reg;

    always_ff @(posedge aclk) begin
        if (entry_we) begin
            entry_mem[entry_waddr] <= entry_wdata;
        end
        rd_entry_reg <= entry_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (rank_we) begin
            rank_mem[rank_waddr] <= rank_wdata;
        end
        rd_rank_reg <= rank_mem[rd_addr];
    end

    assign rd_entry = rd_entry_reg;
    assign rd_rank  = rd_rank_reg;

endmodule : lrutc_store
`default_nettype wire

/* rtl/lru_translation_cache_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lru_translation_cache_unit
// Fully associative translation cache with exact LRU ranks, scanned one
// entry per cycle by a small sequencer.
// ----------------------------------------------------------------------------
//  channel   ports                       direction  contents
//  request   s_valid / s_ready / s_data  in         op, virt_addr, proc_id,
//                                                   new_mach_addr
//  response  m_valid / m_ready / m_data  out        hit, found_mach_addr
//
// one pass over the entry and rank memories reads one entry per cycle
// through the registered read port
// lookup: one pass on a miss; on a hit a second pass updates ranks
// insert: a rank-update pass, then the entry write; when full an extra
// pass first finds the lru victim. s_ready is high only while idle; a held
// response does not block the next request, only the load of the following
// response. reset clears valid bits and occupancy, memories are not cleared
// ----------------------------------------------------------------------------
module lru_translation_cache_unit
    import lrutc_pkg::*;
#(
    parameter int CACHE_ENTRIES = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output      logic        s_ready,
    input  wire lrutc_req_t  s_data,
    output      logic        m_valid,
    input  wire logic        m_ready,
    output      lrutc_resp_t m_data
);

    localparam int IDX_W = $clog2(CACHE_ENTRIES);
    localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_ENTRIES - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CACHE_ENTRIES);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_LK_SCAN  = 3'd1;
    localparam logic [2:0] ST_LK_UPD   = 3'd2;
    localparam logic [2:0] ST_VIC_SCAN = 3'd3;
    localparam logic [2:0] ST_INS_UPD  = 3'd4;
    localparam logic [2:0] ST_INS_WR   = 3'd5;
    localparam logic [2:0] ST_RESP     = 3'd6;

    logic [2:0]         state_reg, state_next;
    lrutc_req_t         req_reg, req_next;
    logic [CNT_W-1:0]   issue_reg, issue_next;
    logic               pv_reg, pv_next;
    logic [IDX_W-1:0]   pidx_reg, pidx_next;
    logic               found_reg, found_next;
    logic [IDX_W-1:0]   best_idx_reg, best_idx_next;
    logic [IDX_W-1:0]   best_rr_reg, best_rr_next;
    logic [IDX_W-1:0]   best_ir_reg, best_ir_next;
    logic [MA_W-1:0]    mach_reg, mach_next;
    logic [CNT_W-1:0]   occ_reg, occ_next;
    logic [CACHE_ENTRIES-1:0] valid_reg;
    logic               set_valid;
    logic               m_valid_reg, m_valid_next;
    lrutc_resp_t        m_data_reg, m_data_next;

    logic [IDX_W-1:0]   rd_addr;
    lrutc_entry_t       rd_entry;
    logic [2*IDX_W-1:0] rd_rank;
    logic [IDX_W-1:0]   rd_rr, rd_ir;
    logic               entry_we;
    lrutc_entry_t       entry_wdata;
    logic               rank_we;
    logic [IDX_W-1:0]   rank_waddr;
    logic [IDX_W-1:0]   wr_rr, wr_ir;

    logic               scanning, scan_last, cur_valid, key_match, full;
    logic [IDX_W-1:0]   rr_aged;

    assign rd_rr     = rd_rank[2*IDX_W-1:IDX_W];
    assign rd_ir     = rd_rank[IDX_W-1:0];
    assign scanning  = (state_reg == ST_LK_SCAN) || (state_reg == ST_LK_UPD) ||
                       (state_reg == ST_VIC_SCAN) || (state_reg == ST_INS_UPD);
    assign scan_last = pv_reg && (pidx_reg == LAST_IDX);
    assign cur_valid = valid_reg[pidx_reg];
    assign key_match = (rd_entry.virt_addr == req_reg.virt_addr) &&
                       (rd_entry.proc_id == req_reg.proc_id);
    assign full      = (occ_reg == FULL_CNT);
    assign rd_addr   = (issue_reg < FULL_CNT) ? issue_reg[IDX_W-1:0] : '0;
    assign rr_aged   = (full && (rd_rr > best_rr_reg)) ? rd_rr - 1'b1 : rd_rr;

    assign entry_wdata.virt_addr = req_reg.virt_addr;
    assign entry_wdata.proc_id   = req_reg.proc_id;
    assign entry_wdata.mach_addr = req_reg.new_mach_addr;

    lrutc_store #(
        .CACHE_ENTRIES (CACHE_ENTRIES)
    ) u_store (
        .aclk        (aclk),
        .rd_addr     (rd_addr),
        .rd_entry    (rd_entry),
        .rd_rank     (rd_rank),
        .entry_we    (entry_we),
        .entry_waddr (best_idx_reg),
        .entry_wdata (entry_wdata),
        .rank_we     (rank_we),
        .rank_waddr  (rank_waddr),
        .rank_wdata  ({wr_rr, wr_ir})
    );

    always_comb begin
        state_next    = state_reg;
        req_next      = req_reg;
        issue_next    = issue_reg;
        pv_next       = pv_reg;
        pidx_next     = pidx_reg;
        found_next    = found_reg;
        best_idx_next = best_idx_reg;
        best_rr_next  = best_rr_reg;
        best_ir_next  = best_ir_reg;
        mach_next     = mach_reg;
        occ_next      = occ_reg;
        set_valid     = 1'b0;
        entry_we      = 1'b0;
        rank_we       = 1'b0;
        rank_waddr    = pidx_reg;
        wr_rr         = rd_rr;
        wr_ir         = rd_ir;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        // read issue for the one-entry-per-cycle scan
        if (scanning) begin
            if (issue_reg < FULL_CNT) begin
                issue_next = issue_reg + 1'b1;
                pv_next    = 1'b1;
                pidx_next  = issue_reg[IDX_W-1:0];
            end else begin
                pv_next = 1'b0;
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    req_next   = s_data;
                    issue_next = '0;
                    pv_next    = 1'b0;
                    found_next = 1'b0;
                    if (s_data.op == OP_LOOKUP) begin
                        state_next = ST_LK_SCAN;
                    end else if (occ_reg == FULL_CNT) begin
                        state_next = ST_VIC_SCAN;
                    end else begin
                        state_next = ST_INS_UPD;
                    end
                end
            end
            ST_LK_SCAN: begin
                // earliest inserted match wins
                if (pv_reg && cur_valid && key_match &&
                    (!found_reg || (rd_ir < best_ir_reg))) begin
                    found_next    = 1'b1;
                    best_idx_next = pidx_reg;
                    best_rr_next  = rd_rr;
                    best_ir_next  = rd_ir;
                    mach_next     = rd_entry.mach_addr;
                end
                if (scan_last) begin
                    issue_next = '0;
                    pv_next    = 1'b0;
                    state_next = found_next ? ST_LK_UPD : ST_RESP;
                end
            end
            ST_LK_UPD: begin
                if (pv_reg && cur_valid) begin
                    rank_we = 1'b1;
                    if (pidx_reg == best_idx_reg) begin
                        wr_rr = '0;
                    end else if (rd_rr < best_rr_reg) begin
                        wr_rr = rd_rr + 1'b1;
                    end
                end
                if (scan_last) begin
                    state_next = ST_RESP;
                end
            end
            ST_VIC_SCAN: begin
                if (pv_reg && cur_valid && (!found_reg || (rd_rr > best_rr_reg))) begin
                    found_next    = 1'b1;
                    best_idx_next = pidx_reg;
                    best_rr_next  = rd_rr;
                    best_ir_next  = rd_ir;
                end
                if (scan_last) begin
                    issue_next = '0;
                    pv_next    = 1'b0;
                    state_next = ST_INS_UPD;
                end
            end
            ST_INS_UPD: begin
                if (pv_reg) begin
                    if (cur_valid && !(full && (pidx_reg == best_idx_reg))) begin
                        // close the victim's gap, then age by one
                        rank_we = 1'b1;
                        wr_rr   = rr_aged + 1'b1;
                        if (full && (rd_ir > best_ir_reg)) begin
                            wr_ir = rd_ir - 1'b1;
                        end
                    end
                    // free slot: first invalid entry
                    if (!full && !cur_valid && !found_reg) begin
                        found_next    = 1'b1;
                        best_idx_next = pidx_reg;
                    end
                end
                if (scan_last) begin
                    state_next = ST_INS_WR;
                end
            end
            ST_INS_WR: begin
                entry_we   = 1'b1;
                rank_we    = 1'b1;
                rank_waddr = best_idx_reg;
                wr_rr      = '0;
                set_valid  = 1'b1;
                if (full) begin
                    wr_ir = LAST_IDX;
                end else begin
                    wr_ir    = occ_reg[IDX_W-1:0];
                    occ_next = occ_reg + 1'b1;
                end
                state_next = ST_RESP;
            end
            ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    if (req_reg.op == OP_INSERT) begin
                        m_data_next.hit             = 1'b1;
                        m_data_next.found_mach_addr = '0;
                    end else begin
                        m_data_next.hit             = found_reg;
                        m_data_next.found_mach_addr = found_reg ? mach_reg : '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            issue_reg   <= '0;
            pv_reg      <= 1'b0;
            found_reg   <= 1'b0;
            occ_reg     <= '0;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            issue_reg   <= issue_next;
            pv_reg      <= pv_next;
            found_reg   <= found_next;
            occ_reg     <= occ_next;
            m_valid_reg <= m_valid_next;
            if (set_valid) begin
                valid_reg[best_idx_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        req_reg      <= req_next;
        pidx_reg     <= pidx_next;
        best_idx_reg <= best_idx_next;
        best_rr_reg  <= best_rr_next;
        best_ir_reg  <= best_ir_next;
        mach_reg     <= mach_next;
        m_data_reg   <= m_data_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule : lru_translation_cache_unit
`default_nettype wire
